[rtl/rrhm_pkg.sv]
// ---------------------------------------------------------------------------
// rrhm_pkg
// Shared types, constants and helper functions of the range result health
// monitor: item layouts, range codes, register indexes and saturating steps.
// ---------------------------------------------------------------------------
`default_nettype none

package rrhm_pkg;

   // field widths
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned DIST_W  = 16;
   localparam int unsigned CODE_W  = 4;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned RUN_W   = 16;
   localparam int unsigned CNT_W   = 32;
   localparam int unsigned CFG_W   = 16;

   // distance scaling: (raw * 2011 + 1024) >> 11
   localparam int unsigned SCALE_MUL_W = 11;
   localparam int unsigned PROD_W      = DIST_W + SCALE_MUL_W;
   localparam int unsigned SCALE_SHIFT = 11;
   localparam logic [SCALE_MUL_W-1:0] SCALE_MUL  = 11'd2011;
   localparam logic [PROD_W-1:0]      SCALE_HALF = 27'h0000400;

   // dense range codes
   localparam logic [CODE_W-1:0] CODE_VALID        = 4'd0;
   localparam logic [CODE_W-1:0] CODE_VALID_NOWRAP = 4'd1;
   localparam logic [CODE_W-1:0] CODE_CLIPPED      = 4'd2;
   localparam logic [CODE_W-1:0] CODE_SIGMA_FAIL   = 4'd3;
   localparam logic [CODE_W-1:0] CODE_SIGNAL_FAIL  = 4'd4;
   localparam logic [CODE_W-1:0] CODE_OUT_OF_BOUND = 4'd5;
   localparam logic [CODE_W-1:0] CODE_HW_FAIL      = 4'd6;
   localparam logic [CODE_W-1:0] CODE_WRAP_FAIL    = 4'd7;
   localparam logic [CODE_W-1:0] CODE_XTALK_FAIL   = 4'd8;
   localparam logic [CODE_W-1:0] CODE_SYNC_INT     = 4'd9;
   localparam logic [CODE_W-1:0] CODE_MIN_RANGE    = 4'd10;
   localparam logic [CODE_W-1:0] CODE_NONE         = 4'd11;
   localparam logic [CODE_W-1:0] CODE_BUS          = 4'd12;

   // raw status byte values from the sensor frame
   localparam logic [BYTE_W-1:0] RAW_HW_FAIL_A    = 8'd1;
   localparam logic [BYTE_W-1:0] RAW_HW_FAIL_B    = 8'd2;
   localparam logic [BYTE_W-1:0] RAW_HW_FAIL_C    = 8'd3;
   localparam logic [BYTE_W-1:0] RAW_SIGNAL_FAIL  = 8'd4;
   localparam logic [BYTE_W-1:0] RAW_OUT_OF_BOUND = 8'd5;
   localparam logic [BYTE_W-1:0] RAW_SIGMA_FAIL   = 8'd6;
   localparam logic [BYTE_W-1:0] RAW_WRAP_FAIL    = 8'd7;
   localparam logic [BYTE_W-1:0] RAW_CLIPPED      = 8'd8;
   localparam logic [BYTE_W-1:0] RAW_VALID        = 8'd9;
   localparam logic [BYTE_W-1:0] RAW_XTALK_FAIL   = 8'd12;
   localparam logic [BYTE_W-1:0] RAW_MIN_RANGE    = 8'd13;
   localparam logic [BYTE_W-1:0] RAW_HW_FAIL_D    = 8'd17;
   localparam logic [BYTE_W-1:0] RAW_SYNC_INT     = 8'd18;

   // register reset values
   localparam logic [CFG_W-1:0]  STALE_MS_RST       = 16'd5000;
   localparam logic [BYTE_W-1:0] MAX_ERROR_RUN_RST  = 8'd12;
   localparam logic [CFG_W-1:0]  RECOVER_PERIOD_RST = 16'd8000;
   localparam logic [CFG_W-1:0]  DIST_LIMIT_RST     = 16'd4000;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_STALE_MS       = 2'd0,
      CSR_MAX_ERROR_RUN  = 2'd1,
      CSR_RECOVER_PERIOD = 2'd2,
      CSR_DISTANCE_LIMIT = 2'd3
   } csr_index_type;

   // input item, first field in the highest bits
   typedef struct packed {
      logic [DIST_W-1:0] raw_distance;
      logic [BYTE_W-1:0] stream_count;
      logic [BYTE_W-1:0] raw_status;
      logic              timed_out;
      logic              bus_error;
      logic              read_ok;
      logic [TIME_W-1:0] now_ms;
   } req_item_type;

   // result item, first field in the highest bits
   typedef struct packed {
      logic [CNT_W-1:0]  recovery_total;
      logic [CNT_W-1:0]  failed_reads;
      logic [CNT_W-1:0]  valid_reads;
      logic [CNT_W-1:0]  total_reads;
      logic              recover_request;
      logic [RUN_W-1:0]  error_run;
      logic              timeout_flag;
      logic              reading_valid;
      logic [CODE_W-1:0] range_code;
      logic [DIST_W-1:0] distance_mm;
   } rsp_item_type;

   localparam int unsigned REQ_W       = $bits(req_item_type);
   localparam int unsigned RSP_W       = $bits(rsp_item_type);
   localparam int unsigned REQ_TDATA_W = ((REQ_W + 7) / 8) * 8;
   localparam int unsigned RSP_TDATA_W = ((RSP_W + 7) / 8) * 8;

   // raw status to dense code
   function automatic logic [CODE_W-1:0] map_status(input logic [BYTE_W-1:0] raw,
                                                    input logic [BYTE_W-1:0] stream);
      logic [CODE_W-1:0] code;
      case (raw) inside
         RAW_HW_FAIL_A, RAW_HW_FAIL_B, RAW_HW_FAIL_C, RAW_HW_FAIL_D:
            code = CODE_HW_FAIL;
         RAW_MIN_RANGE:    code = CODE_MIN_RANGE;
         RAW_SYNC_INT:     code = CODE_SYNC_INT;
         RAW_OUT_OF_BOUND: code = CODE_OUT_OF_BOUND;
         RAW_SIGNAL_FAIL:  code = CODE_SIGNAL_FAIL;
         RAW_SIGMA_FAIL:   code = CODE_SIGMA_FAIL;
         RAW_WRAP_FAIL:    code = CODE_WRAP_FAIL;
         RAW_XTALK_FAIL:   code = CODE_XTALK_FAIL;
         RAW_CLIPPED:      code = CODE_CLIPPED;
         RAW_VALID:        code = (stream == '0) ? CODE_VALID_NOWRAP : CODE_VALID;
         default:          code = CODE_NONE;
      endcase
      return code;
   endfunction

   // saturating increments
   function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [RUN_W-1:0] sat_inc16(input logic [RUN_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

`default_nettype wire

[rtl/range_result_health_monitor_core.sv]
// ---------------------------------------------------------------------------
// range_result_health_monitor_core
// Tracks the health of a range sensor from its read attempts: scales the
// distance, maps the status, keeps the last good reading, counters and the
// recovery request logic.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  req_*     in         req_tvalid/tready    req_tdata  : one read attempt
//  rsp_*     out        rsp_tvalid/tready    rsp_tdata  : record after attempt
//  csr_*     in         csr_valid/ready      csr_index, csr_wdata
//
//  One attempt per cycle is sustained while rsp_tready is high. Three registers
//  follow the transfer in: input register, scaled distance and code register, then
//  the state update that loads the result register. rsp_tvalid rises when the
//  result register is loaded and holds until rsp_tready takes the result. The
//  state update is a single stage, so back-to-back attempts chain with no gap.
//  A stalled rsp lets the empty stages fill; req_tready drops once all three
//  stages hold an item.
//  Reset (synchronous) empties the pipeline, clears the record and counters
//  and restores the register defaults. Register writes are taken every cycle.
//
`default_nettype none

module range_result_health_monitor_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // attempt in: now_ms[31:0], read_ok, bus_error, timed_out,
   // raw_status[7:0], stream_count[7:0], raw_distance[15:0], zero pad
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [rrhm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // result out: distance_mm[15:0], range_code[3:0], reading_valid,
   // timeout_flag, error_run[15:0], recover_request, total_reads[31:0],
   // valid_reads[31:0], failed_reads[31:0], recovery_total[31:0], zero pad
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [rrhm_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   // register writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [1:0]                         csr_index,
   input  wire logic [rrhm_pkg::CFG_W-1:0]         csr_wdata
);

   // configuration registers
   logic [rrhm_pkg::CFG_W-1:0]  stale_ms_ff;
   logic [rrhm_pkg::BYTE_W-1:0] max_error_run_ff;
   logic [rrhm_pkg::CFG_W-1:0]  recover_period_ff;
   logic [rrhm_pkg::CFG_W-1:0]  dist_limit_ff;

   // pipeline registers
   logic                         s1_valid_ff, s1_valid_in;
   rrhm_pkg::req_item_type       s1_item_ff;
   logic                         s2_valid_ff, s2_valid_in;
   logic [rrhm_pkg::TIME_W-1:0]  s2_now_ff;
   logic                         s2_ok_ff;
   logic                         s2_fault_ff;
   logic [rrhm_pkg::DIST_W-1:0]  s2_dist_ff, s2_dist_in;
   logic [rrhm_pkg::CODE_W-1:0]  s2_code_ff, s2_code_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rrhm_pkg::rsp_item_type       rsp_ff, rsp_in;

   // record state
   logic [rrhm_pkg::DIST_W-1:0]  stored_dist_ff, stored_dist_in;
   logic [rrhm_pkg::CODE_W-1:0]  stored_code_ff, stored_code_in;
   logic                         stored_valid_ff, stored_valid_in;
   logic                         stored_timeout_ff, stored_timeout_in;
   logic                         have_update_ff, have_update_in;
   logic [rrhm_pkg::TIME_W-1:0]  last_good_ff, last_good_in;
   logic [rrhm_pkg::RUN_W-1:0]   error_count_ff, error_count_in;
   logic [rrhm_pkg::TIME_W-1:0]  last_recover_ff, last_recover_in;
   logic [rrhm_pkg::CNT_W-1:0]   total_ff, total_in;
   logic [rrhm_pkg::CNT_W-1:0]   valid_cnt_ff, valid_cnt_in;
   logic [rrhm_pkg::CNT_W-1:0]   failed_ff, failed_in;
   logic [rrhm_pkg::CNT_W-1:0]   recover_cnt_ff, recover_cnt_in;

   // handshake and flow control
   logic rsp_room;
   logic s2_advance;
   logic s2_fire;

   assign rsp_room   = !rsp_valid_ff || rsp_tready;
   assign s2_advance = !s2_valid_ff || rsp_room;
   assign s2_fire    = s2_valid_ff && rsp_room;
   assign req_tready = !s1_valid_ff || s2_advance;
   assign csr_ready  = 1'b1;

   assign s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
   assign s2_valid_in  = s2_advance ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = rsp_room ? s2_valid_ff : rsp_valid_ff;

   // distance scaling and status mapping
   logic [rrhm_pkg::PROD_W-1:0] scaled_sum;

   assign scaled_sum = rrhm_pkg::PROD_W'(s1_item_ff.raw_distance)
                       * rrhm_pkg::PROD_W'(rrhm_pkg::SCALE_MUL)
                       + rrhm_pkg::SCALE_HALF;

   always_comb begin
      if (s1_item_ff.read_ok) begin
         s2_dist_in = scaled_sum[rrhm_pkg::SCALE_SHIFT +: rrhm_pkg::DIST_W];
         s2_code_in = rrhm_pkg::map_status(s1_item_ff.raw_status, s1_item_ff.stream_count);
      end else begin
         s2_dist_in = '0;
         s2_code_in = rrhm_pkg::CODE_NONE;
      end
   end

   // classification of the attempt against the stored record
   logic                        bad;
   logic                        stale;
   logic [rrhm_pkg::TIME_W-1:0] good_age;
   logic [rrhm_pkg::TIME_W-1:0] recover_age;
   logic [rrhm_pkg::RUN_W-1:0]  error_inc;
   logic                        recover;

   assign good_age    = s2_now_ff - last_good_ff;
   assign recover_age = s2_now_ff - last_recover_ff;
   assign error_inc   = rrhm_pkg::sat_inc16(error_count_ff);
   assign bad   = !s2_ok_ff || s2_fault_ff || (s2_dist_ff == '0) || (s2_dist_ff >= dist_limit_ff);
   assign stale = !have_update_ff || (good_age > rrhm_pkg::TIME_W'(stale_ms_ff));
   assign recover = bad && stale
                    && (error_inc >= rrhm_pkg::RUN_W'(max_error_run_ff))
                    && (recover_age >= rrhm_pkg::TIME_W'(recover_period_ff));

   // record update
   always_comb begin
      stored_dist_in    = stored_dist_ff;
      stored_code_in    = stored_code_ff;
      stored_valid_in   = stored_valid_ff;
      stored_timeout_in = stored_timeout_ff;
      have_update_in    = have_update_ff;
      last_good_in      = last_good_ff;
      error_count_in    = error_count_ff;
      last_recover_in   = last_recover_ff;
      total_in          = total_ff;
      valid_cnt_in      = valid_cnt_ff;
      failed_in         = failed_ff;
      recover_cnt_in    = recover_cnt_ff;
      if (s2_fire) begin
         total_in = rrhm_pkg::sat_inc32(total_ff);
         if (bad) begin
            if (stale) begin
               stored_valid_in = 1'b0;
               stored_code_in  = s2_fault_ff ? rrhm_pkg::CODE_BUS : s2_code_ff;
            end
            stored_timeout_in = s2_fault_ff;
            error_count_in    = error_inc;
            failed_in         = rrhm_pkg::sat_inc32(failed_ff);
            if (recover) begin
               // recovery clears everything but the recovery time and count
               last_recover_in   = s2_now_ff;
               recover_cnt_in    = rrhm_pkg::sat_inc32(recover_cnt_ff);
               stored_dist_in    = '0;
               stored_code_in    = rrhm_pkg::CODE_VALID;
               stored_valid_in   = 1'b0;
               stored_timeout_in = 1'b0;
               have_update_in    = 1'b0;
               last_good_in      = '0;
               error_count_in    = '0;
               total_in          = '0;
               valid_cnt_in      = '0;
               failed_in         = '0;
            end
         end else begin
            stored_dist_in    = s2_dist_ff;
            stored_code_in    = s2_code_ff;
            stored_valid_in   = (s2_code_ff == rrhm_pkg::CODE_VALID);
            stored_timeout_in = 1'b0;
            last_good_in      = s2_now_ff;
            have_update_in    = 1'b1;
            if (s2_code_ff == rrhm_pkg::CODE_VALID) begin
               error_count_in = '0;
               valid_cnt_in   = rrhm_pkg::sat_inc32(valid_cnt_ff);
            end else begin
               error_count_in = error_inc;
               failed_in      = rrhm_pkg::sat_inc32(failed_ff);
            end
         end
      end
   end

   // result assembly from the updated record
   always_comb begin
      rsp_in.distance_mm     = stored_dist_in;
      rsp_in.range_code      = stored_code_in;
      rsp_in.reading_valid   = stored_valid_in;
      rsp_in.timeout_flag    = stored_timeout_in;
      rsp_in.error_run       = error_count_in;
      rsp_in.recover_request = recover;
      rsp_in.total_reads     = total_in;
      rsp_in.valid_reads     = valid_cnt_in;
      rsp_in.failed_reads    = failed_in;
      rsp_in.recovery_total  = recover_cnt_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stale_ms_ff       <= rrhm_pkg::STALE_MS_RST;
         max_error_run_ff  <= rrhm_pkg::MAX_ERROR_RUN_RST;
         recover_period_ff <= rrhm_pkg::RECOVER_PERIOD_RST;
         dist_limit_ff     <= rrhm_pkg::DIST_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (rrhm_pkg::csr_index_type'(csr_index))
            rrhm_pkg::CSR_STALE_MS:       stale_ms_ff       <= csr_wdata;
            rrhm_pkg::CSR_MAX_ERROR_RUN:  max_error_run_ff  <= csr_wdata[rrhm_pkg::BYTE_W-1:0];
            rrhm_pkg::CSR_RECOVER_PERIOD: recover_period_ff <= csr_wdata;
            rrhm_pkg::CSR_DISTANCE_LIMIT: dist_limit_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (req_tready) begin
         s1_item_ff <= rrhm_pkg::req_item_type'(req_tdata[rrhm_pkg::REQ_W-1:0]);
      end
      if (s2_advance) begin
         s2_now_ff   <= s1_item_ff.now_ms;
         s2_ok_ff    <= s1_item_ff.read_ok;
         s2_fault_ff <= s1_item_ff.bus_error || s1_item_ff.timed_out;
         s2_dist_ff  <= s2_dist_in;
         s2_code_ff  <= s2_code_in;
      end
      if (s2_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // record state
   always_ff @(posedge clock) begin
      if (reset) begin
         stored_dist_ff    <= '0;
         stored_code_ff    <= rrhm_pkg::CODE_VALID;
         stored_valid_ff   <= 1'b0;
         stored_timeout_ff <= 1'b0;
         have_update_ff    <= 1'b0;
         last_good_ff      <= '0;
         error_count_ff    <= '0;
         last_recover_ff   <= '0;
         total_ff          <= '0;
         valid_cnt_ff      <= '0;
         failed_ff         <= '0;
         recover_cnt_ff    <= '0;
      end else begin
         stored_dist_ff    <= stored_dist_in;
         stored_code_ff    <= stored_code_in;
         stored_valid_ff   <= stored_valid_in;
         stored_timeout_ff <= stored_timeout_in;
         have_update_ff    <= have_update_in;
         last_good_ff      <= last_good_in;
         error_count_ff    <= error_count_in;
         last_recover_ff   <= last_recover_in;
         total_ff          <= total_in;
         valid_cnt_ff      <= valid_cnt_in;
         failed_ff         <= failed_in;
         recover_cnt_ff    <= recover_cnt_in;
      end
   end

   // result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(rrhm_pkg::RSP_TDATA_W - rrhm_pkg::RSP_W){1'b0}}, rsp_ff};

endmodule

`default_nettype wire

[rtl/rrhm_checker.sv]
// ---------------------------------------------------------------------------
// rrhm_checker
// Port-level checks of the range result health monitor, bound to the top
// level.
// ---------------------------------------------------------------------------
`default_nettype none

module rrhm_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [rrhm_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   rrhm_pkg::rsp_item_type rsp;

   assign rsp = rrhm_pkg::rsp_item_type'(rsp_tdata[rrhm_pkg::RSP_W-1:0]);

   // a stalled result keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a recovery leaves a cleared record and a counted recovery
   a_recover_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.recover_request |->
         rsp.error_run == '0 && rsp.total_reads == '0 && !rsp.reading_valid
         && rsp.recovery_total != '0)
      else $error("recovery did not clear the record");

   // a valid reading carries the valid code and a nonzero distance
   a_valid_reading: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.reading_valid |->
         rsp.range_code == rrhm_pkg::CODE_VALID && rsp.distance_mm != '0)
      else $error("valid reading with bad code or zero distance");

   // every attempt without recovery is counted
   a_total_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.recover_request |-> rsp.total_reads != '0)
      else $error("attempt not counted");

endmodule

bind range_result_health_monitor_core rrhm_checker u_rrhm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[tb/tb_range_result_health_monitor_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_range_result_health_monitor_core
// Self-checking bench for the range result health monitor. A scoreboard class
// keeps its own copy of the record, counters and registers, predicts the
// record after every accepted read attempt and compares each returned record
// field by field. Directed attempts cover every status byte, faults and the
// distance extremes. Randomised phases with error bursts then run under
// several register settings, with random gaps on both streams, two long
// receiver hold-offs and one long fault burst.
// ---------------------------------------------------------------------------

module tb_range_result_health_monitor_core;

   localparam int unsigned HALF_PERIOD     = 4;
   localparam int unsigned HOLD_CYCLES     = 400;
   localparam int unsigned WATCHDOG_LIMIT  = 4000;
   localparam int unsigned SETTLE_CYCLES   = 6;
   localparam int unsigned PHASE_ITEMS     = 200;
   localparam int unsigned FAULT_ITEMS     = 120;
   localparam int unsigned MAX_REPORTS     = 40;

   // scoreboard: predicted record after each attempt, checked in order
   class health_record_board;
      logic [rrhm_pkg::CFG_W-1:0]  stale_ms;
      logic [rrhm_pkg::BYTE_W-1:0] max_error_run;
      logic [rrhm_pkg::CFG_W-1:0]  recover_period_ms;
      logic [rrhm_pkg::CFG_W-1:0]  distance_limit_mm;

      logic [rrhm_pkg::DIST_W-1:0] stored_distance;
      logic [rrhm_pkg::CODE_W-1:0] stored_code;
      logic                        stored_valid;
      logic                        stored_timeout;
      logic                        have_update;
      logic [rrhm_pkg::TIME_W-1:0] last_good_ms;
      logic [rrhm_pkg::TIME_W-1:0] last_recover_ms;
      logic [rrhm_pkg::RUN_W-1:0]  error_count;
      logic [rrhm_pkg::CNT_W-1:0]  total_reads;
      logic [rrhm_pkg::CNT_W-1:0]  valid_reads;
      logic [rrhm_pkg::CNT_W-1:0]  failed_reads;
      logic [rrhm_pkg::CNT_W-1:0]  recover_count;

      rrhm_pkg::rsp_item_type      pending_records[$];
      int unsigned                 mismatches;
      int unsigned                 records_checked;
      int unsigned                 attempts_noted;
      int unsigned                 recoveries_seen;
      logic [rrhm_pkg::RUN_W-1:0]  longest_run;

      function new();
         stale_ms          = rrhm_pkg::STALE_MS_RST;
         max_error_run     = rrhm_pkg::MAX_ERROR_RUN_RST;
         recover_period_ms = rrhm_pkg::RECOVER_PERIOD_RST;
         distance_limit_mm = rrhm_pkg::DIST_LIMIT_RST;
         last_recover_ms   = '0;
         recover_count     = '0;
         clear_record();
         mismatches      = 0;
         records_checked = 0;
         attempts_noted  = 0;
         recoveries_seen = 0;
         longest_run     = '0;
      endfunction

      // everything except the recovery bookkeeping
      function void clear_record();
         stored_distance = '0;
         stored_code     = rrhm_pkg::CODE_VALID;
         stored_valid    = 1'b0;
         stored_timeout  = 1'b0;
         have_update     = 1'b0;
         last_good_ms    = '0;
         error_count     = '0;
         total_reads     = '0;
         valid_reads     = '0;
         failed_reads    = '0;
      endfunction

      function void write_register(rrhm_pkg::csr_index_type idx,
                                   logic [rrhm_pkg::CFG_W-1:0] value);
         case (idx)
            rrhm_pkg::CSR_STALE_MS:       stale_ms          = value;
            rrhm_pkg::CSR_MAX_ERROR_RUN:  max_error_run     = value[rrhm_pkg::BYTE_W-1:0];
            rrhm_pkg::CSR_RECOVER_PERIOD: recover_period_ms = value;
            rrhm_pkg::CSR_DISTANCE_LIMIT: distance_limit_mm = value;
            default: ;
         endcase
      endfunction

      function logic [rrhm_pkg::CNT_W-1:0] bump32(logic [rrhm_pkg::CNT_W-1:0] v);
         return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
      endfunction

      function logic [rrhm_pkg::RUN_W-1:0] bump16(logic [rrhm_pkg::RUN_W-1:0] v);
         return (v == 16'hFFFF) ? v : v + 16'd1;
      endfunction

      // status byte to dense range code
      function logic [rrhm_pkg::CODE_W-1:0] code_of_status(logic [rrhm_pkg::BYTE_W-1:0] raw,
                                                           logic [rrhm_pkg::BYTE_W-1:0] stream);
         logic [rrhm_pkg::CODE_W-1:0] code;
         code = rrhm_pkg::CODE_NONE;
         if (raw == rrhm_pkg::RAW_HW_FAIL_A || raw == rrhm_pkg::RAW_HW_FAIL_B ||
             raw == rrhm_pkg::RAW_HW_FAIL_C || raw == rrhm_pkg::RAW_HW_FAIL_D)
            code = rrhm_pkg::CODE_HW_FAIL;
         else if (raw == rrhm_pkg::RAW_MIN_RANGE)    code = rrhm_pkg::CODE_MIN_RANGE;
         else if (raw == rrhm_pkg::RAW_SYNC_INT)     code = rrhm_pkg::CODE_SYNC_INT;
         else if (raw == rrhm_pkg::RAW_OUT_OF_BOUND) code = rrhm_pkg::CODE_OUT_OF_BOUND;
         else if (raw == rrhm_pkg::RAW_SIGNAL_FAIL)  code = rrhm_pkg::CODE_SIGNAL_FAIL;
         else if (raw == rrhm_pkg::RAW_SIGMA_FAIL)   code = rrhm_pkg::CODE_SIGMA_FAIL;
         else if (raw == rrhm_pkg::RAW_WRAP_FAIL)    code = rrhm_pkg::CODE_WRAP_FAIL;
         else if (raw == rrhm_pkg::RAW_XTALK_FAIL)   code = rrhm_pkg::CODE_XTALK_FAIL;
         else if (raw == rrhm_pkg::RAW_CLIPPED)      code = rrhm_pkg::CODE_CLIPPED;
         else if (raw == rrhm_pkg::RAW_VALID)
            code = (stream == 8'd0) ? rrhm_pkg::CODE_VALID_NOWRAP : rrhm_pkg::CODE_VALID;
         return code;
      endfunction

      // advance the record by one attempt and return what the block reports
      function rrhm_pkg::rsp_item_type predict_record(rrhm_pkg::req_item_type a);
         rrhm_pkg::rsp_item_type      r;
         logic [31:0]                 prod;
         logic [rrhm_pkg::DIST_W-1:0] scaled_mm;
         logic [rrhm_pkg::CODE_W-1:0] code;
         logic [rrhm_pkg::TIME_W-1:0] age;
         logic [rrhm_pkg::TIME_W-1:0] since_recover;
         logic                        fault;
         logic                        stale;
         logic                        recover;
         fault     = a.bus_error | a.timed_out;
         scaled_mm = '0;
         code      = rrhm_pkg::CODE_NONE;
         recover   = 1'b0;
         if (a.read_ok) begin
            prod      = {16'd0, a.raw_distance} * 32'd2011 + 32'd1024;
            scaled_mm = prod[26:11];
            code      = code_of_status(a.raw_status, a.stream_count);
         end
         total_reads    = bump32(total_reads);
         stored_timeout = 1'b0;

         if (!a.read_ok || fault || scaled_mm == '0 || scaled_mm >= distance_limit_mm) begin
            // bad attempt: stored code and valid flag only change once the last good reading is stale
            age   = a.now_ms - last_good_ms;
            stale = !have_update || (age > {16'd0, stale_ms});
            if (stale) begin
               stored_valid = 1'b0;
               stored_code  = fault ? rrhm_pkg::CODE_BUS : code;
            end
            stored_timeout = fault;
            error_count    = bump16(error_count);
            failed_reads   = bump32(failed_reads);
            since_recover  = a.now_ms - last_recover_ms;
            if (error_count >= {8'd0, max_error_run} && stale &&
                since_recover >= {16'd0, recover_period_ms}) begin
               recover         = 1'b1;
               last_recover_ms = a.now_ms;
               recover_count   = bump32(recover_count);
               clear_record();
            end
         end else begin
            // good attempt replaces the stored reading
            stored_distance = scaled_mm;
            stored_code     = code;
            stored_valid    = (code == rrhm_pkg::CODE_VALID);
            last_good_ms    = a.now_ms;
            have_update     = 1'b1;
            if (stored_valid) begin
               error_count = '0;
               valid_reads = bump32(valid_reads);
            end else begin
               error_count  = bump16(error_count);
               failed_reads = bump32(failed_reads);
            end
         end
         if (error_count > longest_run) longest_run = error_count;

         r.distance_mm     = stored_distance;
         r.range_code      = stored_code;
         r.reading_valid   = stored_valid;
         r.timeout_flag    = stored_timeout;
         r.error_run       = error_count;
         r.recover_request = recover;
         r.total_reads     = total_reads;
         r.valid_reads     = valid_reads;
         r.failed_reads    = failed_reads;
         r.recovery_total  = recover_count;
         return r;
      endfunction

      function void note_attempt(rrhm_pkg::req_item_type a);
         attempts_noted++;
         pending_records.push_back(predict_record(a));
      endfunction

      function int unsigned pending();
         return pending_records.size();
      endfunction

      task report_mismatch(string msg);
         if (mismatches < MAX_REPORTS) $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("record %0d %s: got %0h, expected %0h",
                                      records_checked, name, got, want));
      endtask

      task check_record(rrhm_pkg::rsp_item_type got);
         rrhm_pkg::rsp_item_type want;
         if (pending_records.size() == 0) begin
            report_mismatch($sformatf("record with no attempt outstanding, distance %0d",
                                      got.distance_mm));
            return;
         end
         want = pending_records.pop_front();
         records_checked++;
         if (want.recover_request) recoveries_seen++;
         compare_field("distance_mm",     got.distance_mm,     want.distance_mm);
         compare_field("range_code",      got.range_code,      want.range_code);
         compare_field("reading_valid",   got.reading_valid,   want.reading_valid);
         compare_field("timeout_flag",    got.timeout_flag,    want.timeout_flag);
         compare_field("error_run",       got.error_run,       want.error_run);
         compare_field("recover_request", got.recover_request, want.recover_request);
         compare_field("total_reads",     got.total_reads,     want.total_reads);
         compare_field("valid_reads",     got.valid_reads,     want.valid_reads);
         compare_field("failed_reads",    got.failed_reads,    want.failed_reads);
         compare_field("recovery_total",  got.recovery_total,  want.recovery_total);
      endtask
   endclass

   // clock, reset and block inputs, all known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [rrhm_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [rrhm_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [1:0]                       csr_index  = rrhm_pkg::CSR_STALE_MS;
   logic [rrhm_pkg::CFG_W-1:0]       csr_wdata  = '0;

   health_record_board sb;

   bit                          calm         = 1'b0;
   bit                          hold_off_req = 1'b0;
   logic [rrhm_pkg::TIME_W-1:0] sim_ms       = '0;
   int unsigned                 bad_run_left = 0;
   int unsigned                 phases_run   = 0;
   int unsigned                 idle_cycles  = 0;

   logic [rrhm_pkg::BYTE_W-1:0] status_pool [13] = '{
      rrhm_pkg::RAW_HW_FAIL_A, rrhm_pkg::RAW_HW_FAIL_B, rrhm_pkg::RAW_HW_FAIL_C,
      rrhm_pkg::RAW_SIGNAL_FAIL, rrhm_pkg::RAW_OUT_OF_BOUND, rrhm_pkg::RAW_SIGMA_FAIL,
      rrhm_pkg::RAW_WRAP_FAIL, rrhm_pkg::RAW_CLIPPED, rrhm_pkg::RAW_VALID,
      rrhm_pkg::RAW_XTALK_FAIL, rrhm_pkg::RAW_MIN_RANGE, rrhm_pkg::RAW_HW_FAIL_D,
      rrhm_pkg::RAW_SYNC_INT
   };

   range_result_health_monitor_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // gap lengths: mostly short, a few long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 75) return $urandom_range(3, 1);
      if (roll < 95) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic rrhm_pkg::req_item_type attempt(logic [rrhm_pkg::TIME_W-1:0] at_ms,
                                                      logic ok, logic bus, logic tmo,
                                                      logic [rrhm_pkg::BYTE_W-1:0] status,
                                                      logic [rrhm_pkg::BYTE_W-1:0] stream,
                                                      logic [rrhm_pkg::DIST_W-1:0] raw);
      rrhm_pkg::req_item_type a;
      a.now_ms       = at_ms;
      a.read_ok      = ok;
      a.bus_error    = bus;
      a.timed_out    = tmo;
      a.raw_status   = status;
      a.stream_count = stream;
      a.raw_distance = raw;
      return a;
   endfunction

   // random read attempt, bad ones partly in bursts so that recovery is reached
   function automatic rrhm_pkg::req_item_type random_attempt();
      rrhm_pkg::req_item_type a;
      int unsigned            roll;
      int unsigned            lim;
      int unsigned            top;
      bit                     bad;
      roll = $urandom_range(99);
      if (roll < 65)      sim_ms = sim_ms + $urandom_range(200, 1);
      else if (roll < 90) sim_ms = sim_ms + $urandom_range(3000, 200);
      else if (roll < 97) sim_ms = sim_ms + $urandom_range(20000, 3000);
      else if (roll < 99) sim_ms = $urandom();

      if (bad_run_left != 0) begin
         bad_run_left--;
         bad = 1'b1;
      end else if ($urandom_range(99) < 8) begin
         bad_run_left = $urandom_range(40, 3);
         bad = 1'b1;
      end else begin
         bad = ($urandom_range(99) < 25);
      end

      lim            = sb.distance_limit_mm;
      a.now_ms       = sim_ms;
      a.read_ok      = 1'b1;
      a.bus_error    = 1'b0;
      a.timed_out    = 1'b0;
      a.stream_count = ($urandom_range(99) < 15) ? 8'd0 : 8'($urandom_range(255));
      roll = $urandom_range(99);
      if (roll < 65)      a.raw_status = rrhm_pkg::RAW_VALID;
      else if (roll < 88) a.raw_status = status_pool[$urandom_range(12)];
      else                a.raw_status = 8'($urandom_range(255));

      // distance that scales to somewhere in 1 .. limit-1
      top = (lim > 2) ? ((lim - 2) * 2048) / 2011 : 1;
      if (top > 65535) top = 65535;
      if (top < 1) top = 1;
      a.raw_distance = 16'($urandom_range(top, 1));

      if (bad) begin
         case ($urandom_range(4))
            0: begin
               a.read_ok      = 1'b0;
               a.raw_distance = 16'($urandom_range(65535));
            end
            1: begin
               a.bus_error = 1'b1;
               a.timed_out = 1'($urandom_range(1));
               a.read_ok   = 1'($urandom_range(1));
            end
            2: begin
               a.timed_out = 1'b1;
               a.read_ok   = 1'($urandom_range(1));
            end
            3: a.raw_distance = 16'd0;
            default: begin
               top = (lim * 2048) / 2011 + 1;
               if (top > 65535) top = 65535;
               a.raw_distance = 16'($urandom_range(65535, top));
            end
         endcase
      end
      return a;
   endfunction

   // one attempt transfer on the request stream
   task automatic send_attempt(rrhm_pkg::req_item_type a);
      int unsigned                      gap;
      logic [rrhm_pkg::REQ_TDATA_W-1:0] word;
      gap  = (calm || $urandom_range(99) < 55) ? 0 : pick_gap();
      word = '0;
      word[rrhm_pkg::REQ_W-1:0] = a;
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_attempt(a);
   endtask

   task automatic write_csr(rrhm_pkg::csr_index_type idx, logic [rrhm_pkg::CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop offering and wait until every record is back and the pipe is empty
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_registers(logic [rrhm_pkg::CFG_W-1:0] stale,
                                 logic [rrhm_pkg::BYTE_W-1:0] run,
                                 logic [rrhm_pkg::CFG_W-1:0] period,
                                 logic [rrhm_pkg::CFG_W-1:0] limit);
      settle();
      write_csr(rrhm_pkg::CSR_STALE_MS, stale);
      write_csr(rrhm_pkg::CSR_MAX_ERROR_RUN, {8'd0, run});
      write_csr(rrhm_pkg::CSR_RECOVER_PERIOD, period);
      write_csr(rrhm_pkg::CSR_DISTANCE_LIMIT, limit);
      phases_run++;
   endtask

   task automatic run_phase(logic [rrhm_pkg::CFG_W-1:0] stale,
                            logic [rrhm_pkg::BYTE_W-1:0] run,
                            logic [rrhm_pkg::CFG_W-1:0] period,
                            logic [rrhm_pkg::CFG_W-1:0] limit,
                            bit quiet, bit squeeze);
      load_registers(stale, run, period, limit);
      calm = quiet;
      if (squeeze) hold_off_req = 1'b1;
      repeat (PHASE_ITEMS) send_attempt(random_attempt());
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (calm) begin
            rsp_tready <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(99) < 25) stall_left = pick_gap();
         end
      end
   end

   // record check on every response transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_record(rsp_tdata[rrhm_pkg::RSP_W-1:0]);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      @(posedge clock);
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog: no transfer for %0d cycles, %0d records outstanding",
               WATCHDOG_LIMIT, sb.pending());
      $display("FAIL range_result_health_monitor_core");
      $finish;
   end

   initial begin : stimulus
      int unsigned k;
      sb = new();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed attempts under the reset register values
      sim_ms = 32'd100;
      send_attempt(attempt(sim_ms, 1'b1, 1'b0, 1'b0, rrhm_pkg::RAW_VALID, 8'd5, 16'd1018));
      send_attempt(attempt(sim_ms + 10, 1'b1, 1'b0, 1'b0, rrhm_pkg::RAW_VALID, 8'd0,
                           16'd1018));
      send_attempt(attempt(sim_ms + 20, 1'b1, 1'b0, 1'b0, rrhm_pkg::RAW_VALID, 8'd7, 16'd0));
      send_attempt(attempt(sim_ms + 30, 1'b1, 1'b0, 1'b0, rrhm_pkg::RAW_VALID, 8'd8, 16'd1));
      send_attempt(attempt(sim_ms + 40, 1'b1, 1'b0, 1'b0, rrhm_pkg::RAW_VALID, 8'hFF,
                           16'hFFFF));
      send_attempt(attempt(sim_ms + 50, 1'b0, 1'b0, 1'b0, rrhm_pkg::RAW_VALID, 8'd1,
                           16'd500));
      send_attempt(attempt(sim_ms + 60, 1'b1, 1'b1, 1'b0, rrhm_pkg::RAW_VALID, 8'd2,
                           16'd500));
      send_attempt(attempt(sim_ms + 70, 1'b1, 1'b0, 1'b1, rrhm_pkg::RAW_VALID, 8'd3,
                           16'd500));
      send_attempt(attempt(sim_ms + 80, 1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF, 16'hFFFF));
      sim_ms = sim_ms + 100;
      // every status byte other than valid, plus two that map to none
      for (k = 0; k < 13; k++) begin
         if (status_pool[k] != rrhm_pkg::RAW_VALID) begin
            send_attempt(attempt(sim_ms, 1'b1, 1'b0, 1'b0, status_pool[k], 8'd3, 16'd2000));
            sim_ms = sim_ms + 10;
         end
      end
      send_attempt(attempt(sim_ms, 1'b1, 1'b0, 1'b0, 8'd0, 8'd3, 16'd2000));
      send_attempt(attempt(sim_ms + 5, 1'b1, 1'b0, 1'b0, 8'hFF, 8'd3, 16'd2000));
      // stale bad attempt, then a good reading across the timestamp wrap
      send_attempt(attempt(sim_ms + 6000, 1'b1, 1'b0, 1'b0, rrhm_pkg::RAW_SIGMA_FAIL, 8'd1,
                           16'hF000));
      send_attempt(attempt(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0, rrhm_pkg::RAW_VALID, 8'd9,
                           16'd3000));
      send_attempt(attempt(32'h0000_0010, 1'b1, 1'b0, 1'b0, rrhm_pkg::RAW_VALID, 8'd9,
                           16'd3500));
      sim_ms = 32'h0000_0020;

      // random phases over a spread of register settings
      run_phase(rrhm_pkg::STALE_MS_RST, rrhm_pkg::MAX_ERROR_RUN_RST,
                rrhm_pkg::RECOVER_PERIOD_RST, rrhm_pkg::DIST_LIMIT_RST, 1'b0, 1'b0);
      run_phase(16'd0, 8'd1, 16'd0, 16'hFFFF, 1'b0, 1'b0);
      run_phase(16'hFFFF, 8'hFF, 16'hFFFF, 16'd1, 1'b0, 1'b0);
      run_phase(16'd100, 8'd0, 16'd500, 16'd0, 1'b0, 1'b0);
      run_phase(16'($urandom_range(8000)), 8'($urandom_range(20, 1)),
                16'($urandom_range(10000)), 16'($urandom_range(65535, 1)), 1'b1, 1'b1);
      sim_ms = 32'hFFFF_F000;
      run_phase(16'($urandom_range(65535)), 8'($urandom_range(255, 1)),
                16'($urandom_range(65535)), 16'($urandom_range(65535, 1)), 1'b0, 1'b0);
      run_phase(16'd2000, 8'd3, 16'd1500, 16'd4000, 1'b0, 1'b0);
      run_phase(16'($urandom_range(65535)), 8'($urandom_range(255, 1)),
                16'($urandom_range(3000)), 16'($urandom_range(65535, 1)), 1'b0, 1'b1);

      // long fault run at a fixed timestamp: error run climbs, no recovery
      load_registers(16'd0, 8'hFF, 16'hFFFF, rrhm_pkg::DIST_LIMIT_RST);
      calm = 1'b1;
      repeat (FAULT_ITEMS)
         send_attempt(attempt(sb.last_recover_ms + 32'd1, 1'($urandom_range(1)), 1'b1,
                              1'($urandom_range(1)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 16'($urandom_range(65535))));
      calm = 1'b0;
      run_phase(16'd300, 8'd2, 16'd0, 16'd2500, 1'b0, 1'b0);

      // drain and let any stray record show up
      settle();
      repeat (10) @(posedge clock);

      $display("run covered %0d read attempts over %0d register settings",
               sb.attempts_noted, phases_run + 1);
      $display("%0d records checked, %0d recovery requests, longest error run %0d",
               sb.records_checked, sb.recoveries_seen, sb.longest_run);
      if (sb.mismatches == 0)
         $display("PASS range_result_health_monitor_core");
      else
         $display("FAIL range_result_health_monitor_core");
      $finish;
   end

endmodule
